>>> design/stsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stsd_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_RANGE      = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_e;

  // Result kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_DIM   = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE         = 2'd0,
    REG_HAS_LEAD     = 2'd1,
    REG_FIRST_FACTOR = 2'd2,
    REG_VALIDATE     = 2'd3
  } cfg_reg_e;

  localparam int unsigned FACTOR_W     = 16;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned QUEUE_DEPTH  = 4;
  // Result buffer depth, kept a power of two so its pointers wrap freely
  localparam int unsigned RESULT_DEPTH = 4;

  // Mode bits taken from the configuration registers
  typedef struct packed {
    logic has_lead;
    logic validate;
  } mode_t;

  // Classification of one dimension, worked out at the front
  typedef struct packed {
    logic    keep;
    logic    last;
    status_e vstatus;
  } cls_t;

endpackage

`default_nettype wire

>>> design/stsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stsd_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [LENGTH_BITS-1:0] dim_length_i,
  input  logic [LENGTH_BITS-1:0] dim_factor_next_i,
  input  logic [LENGTH_BITS-1:0] slice_start_i,
  input  logic [LENGTH_BITS-1:0] slice_length_i,
  input  logic                   last_dim_i,
  input  stsd_pkg::mode_t        mode_i,
  output logic                   item_valid_o,
  input  logic                   item_ready_i,
  output logic [LENGTH_BITS-1:0] start_o,
  output logic [LENGTH_BITS-1:0] length_o,
  output logic [LENGTH_BITS-1:0] factor_o,
  output stsd_pkg::cls_t         cls_o
);
  import stsd_pkg::*;

  logic                   keep;
  logic [LENGTH_BITS-1:0] need;
  logic [LENGTH_BITS:0]   range_end;
  logic [LENGTH_BITS-1:0] next_factor;
  status_e                vstatus;

  logic                   vld_q, vld_d;
  logic [LENGTH_BITS-1:0] start_q, length_q, factor_q;
  cls_t                   cls_q;

  // Bounds checks on start and length
  assign keep      = |slice_length_i;
  assign need      = keep ? slice_length_i : LENGTH_BITS'(1);
  assign range_end = {1'b0, slice_start_i} + {1'b0, need};

  always_comb begin
    priority if (!mode_i.validate) begin
      vstatus = ST_OK;
    end else if (slice_start_i >= dim_length_i) begin
      vstatus = ST_BAD_START;
    end else if (slice_length_i > dim_length_i) begin
      vstatus = ST_BAD_LENGTH;
    end else if (range_end > {1'b0, dim_length_i}) begin
      vstatus = ST_RANGE;
    end else begin
      vstatus = ST_OK;
    end
  end

  // Factor that scales the following dimension
  assign next_factor = (mode_i.has_lead && !last_dim_i) ? dim_factor_next_i : dim_length_i;

  // Holding register towards the queue
  assign in_ready_o = !vld_q || item_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      start_q       <= slice_start_i;
      length_q      <= slice_length_i;
      factor_q      <= next_factor;
      cls_q.keep    <= keep;
      cls_q.last    <= last_dim_i;
      cls_q.vstatus <= vstatus;
    end
  end

  assign item_valid_o = vld_q;
  assign start_o      = start_q;
  assign length_o     = length_q;
  assign factor_o     = factor_q;
  assign cls_o        = cls_q;

endmodule

`default_nettype wire

>>> design/stsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module stsd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q < CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/stsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stsd_back #(
  parameter int unsigned MAX_DIMS     = 16,
  parameter int unsigned LENGTH_BITS  = 16,
  parameter int unsigned ADDRESS_BITS = 48,
  localparam int unsigned POS_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int unsigned CNT_W       = $clog2(MAX_DIMS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  output logic                    item_ready_o,
  input  logic [LENGTH_BITS-1:0]  start_i,
  input  logic [LENGTH_BITS-1:0]  length_i,
  input  logic [LENGTH_BITS-1:0]  factor_i,
  input  stsd_pkg::cls_t          cls_i,
  input  stsd_pkg::mode_t         mode_i,
  input  logic [ADDRESS_BITS-1:0] base_i,
  input  logic [stsd_pkg::FACTOR_W-1:0] first_factor_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output stsd_pkg::kind_e         kind_o,
  output logic [LENGTH_BITS-1:0]  length_o,
  output logic [ADDRESS_BITS-1:0] leading_o,
  output logic [POS_W-1:0]        position_o,
  output logic [ADDRESS_BITS-1:0] address_o,
  output logic [CNT_W-1:0]        count_o,
  output stsd_pkg::status_e       status_o,
  output logic                    last_o
);
  import stsd_pkg::*;

  localparam int unsigned A      = ADDRESS_BITS;
  localparam int unsigned L      = LENGTH_BITS;
  localparam int unsigned PW     = A + L;
  localparam int unsigned O_LEN  = KIND_W;
  localparam int unsigned O_LEAD = O_LEN + L;
  localparam int unsigned O_POS  = O_LEAD + A;
  localparam int unsigned O_ADDR = O_POS + POS_W;
  localparam int unsigned O_CNT  = O_ADDR + A;
  localparam int unsigned O_ST   = O_CNT + CNT_W;
  localparam int unsigned O_LAST = O_ST + STATUS_W;
  localparam int unsigned RW     = O_LAST + 1;
  localparam int unsigned RPW    = $clog2(RESULT_DEPTH);
  localparam int unsigned RCW    = $clog2(RESULT_DEPTH + 1);

  logic advance;

  // Stride loop state
  logic [A-1:0]     stride_q, lead_q;
  logic [CNT_W-1:0] kept_q;
  logic             first_q;
  logic [A-1:0]     seed, stride_cur, lead_cur;
  logic [CNT_W-1:0] kept_cur, kept_next;
  logic [PW-1:0]    p_off, p_stride, p_lead;
  logic             ovf_pos, ovf_next, ovf_kept;

  // Stage A registers
  logic             a_vld_q;
  logic [A-1:0]     a_poff_q, a_lead_q;
  logic             a_ovf_q, a_first_q;
  logic [POS_W-1:0] a_pos_q;
  logic [CNT_W-1:0] a_kept_q;
  logic [L-1:0]     a_len_q;
  cls_t             a_cls_q;

  // Offset accumulator and stage B registers
  logic [A-1:0]     off_q;
  logic [A:0]       off_sum;
  logic             b_vld_q;
  logic [A-1:0]     b_off_q, b_lead_q;
  logic             b_ovf_q;
  logic [POS_W-1:0] b_pos_q;
  logic [CNT_W-1:0] b_kept_q;
  logic [L-1:0]     b_len_q;
  cls_t             b_cls_q;

  // Address, status and result selection
  logic [A-1:0]     shifted;
  logic [A:0]       addr_sum;
  logic             ovf_addr;
  status_e          status;
  logic             failed_q, failed_d;
  logic [RW-1:0]    res_dim, res_addr, res_err, res0, res1;
  logic [1:0]       n_wr;

  // Result buffer
  logic [RW-1:0]    rbuf_q [RESULT_DEPTH];
  logic [RPW-1:0]   rd_q, wr_q;
  logic [RCW-1:0]   cnt_q;
  logic             pop;
  logic [RW-1:0]    head;

  // The whole pipeline moves while the buffer has room for two results
  assign advance      = cnt_q <= RCW'(RESULT_DEPTH - 2);
  assign item_ready_o = advance;

  // Stride loop: element offset term and factors for the next dimension
  assign seed       = mode_i.has_lead ? A'(first_factor_i) : A'(1);
  assign stride_cur = first_q ? seed : stride_q;
  assign lead_cur   = first_q ? seed : lead_q;
  assign kept_cur   = first_q ? '0 : kept_q;

  assign p_off    = PW'(stride_cur) * PW'(start_i);
  assign p_stride = PW'(stride_cur) * PW'(factor_i);
  assign p_lead   = PW'(lead_cur) * PW'(factor_i);

  assign ovf_pos  = |p_off[PW-1:A];
  assign ovf_next = !cls_i.last && ((|p_stride[PW-1:A]) || (!cls_i.keep && (|p_lead[PW-1:A])));
  assign ovf_kept = cls_i.keep && (kept_cur >= CNT_W'(MAX_DIMS));
  assign kept_next = (cls_i.keep && !ovf_kept) ? kept_cur + CNT_W'(1) : kept_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= A'(1);
      lead_q   <= A'(1);
      kept_q   <= '0;
      first_q  <= 1'b1;
    end else if (advance && item_valid_i) begin
      stride_q <= p_stride[A-1:0];
      lead_q   <= cls_i.keep ? A'(factor_i) : p_lead[A-1:0];
      kept_q   <= kept_next;
      first_q  <= cls_i.last;
    end
  end

  // Offset accumulation, cleared at the first dimension of a descriptor
  assign off_sum = {1'b0, (a_first_q ? '0 : off_q)} + {1'b0, a_poff_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (advance && a_vld_q) begin
      off_q <= off_sum[A-1:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (advance) begin
      a_vld_q <= item_valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_poff_q  <= p_off[A-1:0];
      a_ovf_q   <= ovf_pos || ovf_next || ovf_kept;
      a_lead_q  <= lead_cur;
      a_pos_q   <= kept_cur[POS_W-1:0];
      a_kept_q  <= kept_next;
      a_len_q   <= length_i;
      a_first_q <= first_q;
      a_cls_q   <= cls_i;
      b_off_q   <= off_sum[A-1:0];
      b_ovf_q   <= a_ovf_q || off_sum[A];
      b_lead_q  <= a_lead_q;
      b_pos_q   <= a_pos_q;
      b_kept_q  <= a_kept_q;
      b_len_q   <= a_len_q;
      b_cls_q   <= a_cls_q;
    end
  end

  // Byte address of the slice base, only checked on the last dimension
  assign shifted  = {b_off_q[A-4:0], 3'b000};
  assign addr_sum = {1'b0, base_i} + {1'b0, shifted};
  assign ovf_addr = b_cls_q.last && ((|b_off_q[A-1:A-3]) || addr_sum[A]);

  always_comb begin
    priority if (b_cls_q.vstatus != ST_OK) begin
      status = b_cls_q.vstatus;
    end else if (b_ovf_q || ovf_addr) begin
      status = ST_OVERFLOW;
    end else begin
      status = ST_OK;
    end
  end

  // Packed results, kind in the lowest bits
  assign res_dim  = {1'b0, ST_OK, {CNT_W{1'b0}}, {A{1'b0}}, b_pos_q, b_lead_q, b_len_q,
                     KIND_DIM};
  assign res_addr = {1'b1, ST_OK, b_kept_q, addr_sum[A-1:0], {POS_W{1'b0}}, {A{1'b0}},
                     {L{1'b0}}, KIND_ADDR};
  assign res_err  = {1'b1, status, {CNT_W{1'b0}}, {A{1'b0}}, {POS_W{1'b0}}, {A{1'b0}},
                     {L{1'b0}}, KIND_ERROR};

  // Results of one dimension; a failed descriptor stays silent up to its last dimension
  always_comb begin
    n_wr     = 2'd0;
    res0     = res_err;
    res1     = res_addr;
    failed_d = failed_q;
    if (advance && b_vld_q) begin
      if (failed_q) begin
        failed_d = !b_cls_q.last;
      end else if (status != ST_OK) begin
        n_wr     = 2'd1;
        failed_d = !b_cls_q.last;
      end else if (b_cls_q.keep) begin
        res0 = res_dim;
        n_wr = b_cls_q.last ? 2'd2 : 2'd1;
      end else begin
        res0 = res_addr;
        n_wr = b_cls_q.last ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q <= 1'b0;
    end else begin
      failed_q <= failed_d;
    end
  end

  // Result buffer, up to two writes and one read per cycle
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign head        = rbuf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + RPW'(pop);
      wr_q  <= wr_q + RPW'(n_wr);
      cnt_q <= cnt_q + RCW'(n_wr) - RCW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      rbuf_q[wr_q] <= res0;
    end
    if (n_wr == 2'd2) begin
      rbuf_q[wr_q + RPW'(1)] <= res1;
    end
  end

  assign kind_o     = kind_e'(head[KIND_W-1:0]);
  assign length_o   = head[O_LEAD-1:O_LEN];
  assign leading_o  = head[O_POS-1:O_LEAD];
  assign position_o = head[O_ADDR-1:O_POS];
  assign address_o  = head[O_CNT-1:O_ADDR];
  assign count_o    = head[O_ST-1:O_CNT];
  assign status_o   = status_e'(head[O_LAST-1:O_ST]);
  assign last_o     = head[O_LAST];

endmodule

`default_nettype wire

>>> design/strided_tensor_slice_descriptor_unit.sv
// Strided tensor slice descriptor unit. A source tensor descriptor arrives one dimension per
// transfer (length, factor of the next dimension, slice start, slice length, tlast on the
// final dimension). Every kept dimension (slice length not zero) yields one result with its
// length, leading factor and output position; the final dimension also yields the byte
// address base + 8 * element offset and the kept count, with tlast. A bad start, length,
// range or an arithmetic overflow yields a single error result with tlast, and the rest of
// that descriptor gives nothing. One dimension is taken every clock cycle while the back end
// has room for two results; the rate is set by the combinational stride multipliers of the
// back end, whose running stride feeds the next dimension. A final dimension with a kept
// slice gives two results. An input passes through the front register, the queue, the two
// back stages and the result buffer before its first result. Configuration registers take
// effect on the next descriptor and are to be written while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none

module strided_tensor_slice_descriptor_unit #(
  parameter int unsigned MAX_DIMS     = 16,
  parameter int unsigned LENGTH_BITS  = 16,
  parameter int unsigned ADDRESS_BITS = 48,
  localparam int unsigned POS_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int unsigned CNT_W       = $clog2(MAX_DIMS + 1),
  localparam int unsigned IN_W        = ((4 * LENGTH_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS    = LENGTH_BITS + 2 * ADDRESS_BITS + POS_W + CNT_W + 3,
  localparam int unsigned OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  stsd_pkg::cfg_reg_e        cfg_idx_i,
  input  logic [ADDRESS_BITS-1:0]   cfg_data_i,
  // dimension input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // dim_length, dim_factor_next, slice_start, slice_length
  input  logic [IN_W-1:0]           s_axis_tdata,
  input  logic                      s_axis_tlast,   // last_dim
  // results
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // out_length, out_leading, out_position, slice_address, kept_count, status
  output logic [OUT_W-1:0]          m_axis_tdata,
  output logic [stsd_pkg::KIND_W-1:0] m_axis_tuser, // kind
  output logic                      m_axis_tlast    // last
);
  import stsd_pkg::*;

  localparam int unsigned L  = LENGTH_BITS;
  localparam int unsigned QW = 3 * L + $bits(cls_t);

  // Configuration registers
  logic [ADDRESS_BITS-1:0] base_q;
  logic                    has_lead_q, validate_q;
  logic [FACTOR_W-1:0]     first_factor_q;
  mode_t                   mode;

  // Front to queue to back
  logic          f_valid, f_ready;
  logic [L-1:0]  f_start, f_length, f_factor;
  cls_t          f_cls;
  logic [QW-1:0] q_in, q_out;
  logic          q_valid, q_ready;
  logic [L-1:0]  q_start, q_length, q_factor;
  cls_t          q_cls;

  // Result fields
  kind_e                   r_kind;
  logic [L-1:0]            r_length;
  logic [ADDRESS_BITS-1:0] r_leading, r_address;
  logic [POS_W-1:0]        r_position;
  logic [CNT_W-1:0]        r_count;
  status_e                 r_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q         <= '0;
      has_lead_q     <= 1'b0;
      first_factor_q <= FACTOR_W'(1);
      validate_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE:         base_q         <= cfg_data_i;
        REG_HAS_LEAD:     has_lead_q     <= cfg_data_i[0];
        REG_FIRST_FACTOR: first_factor_q <= cfg_data_i[FACTOR_W-1:0];
        REG_VALIDATE:     validate_q     <= cfg_data_i[0];
      endcase
    end
  end

  assign mode.has_lead = has_lead_q;
  assign mode.validate = validate_q;

  stsd_front #(
    .LENGTH_BITS (L)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .dim_length_i      (s_axis_tdata[L-1:0]),
    .dim_factor_next_i (s_axis_tdata[2*L-1:L]),
    .slice_start_i     (s_axis_tdata[3*L-1:2*L]),
    .slice_length_i    (s_axis_tdata[4*L-1:3*L]),
    .last_dim_i        (s_axis_tlast),
    .mode_i            (mode),
    .item_valid_o      (f_valid),
    .item_ready_i      (f_ready),
    .start_o           (f_start),
    .length_o          (f_length),
    .factor_o          (f_factor),
    .cls_o             (f_cls)
  );

  assign q_in = {f_cls, f_factor, f_length, f_start};

  stsd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_out)
  );

  assign q_start  = q_out[L-1:0];
  assign q_length = q_out[2*L-1:L];
  assign q_factor = q_out[3*L-1:2*L];
  assign q_cls    = cls_t'(q_out[QW-1:3*L]);

  stsd_back #(
    .MAX_DIMS     (MAX_DIMS),
    .LENGTH_BITS  (L),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .start_i        (q_start),
    .length_i       (q_length),
    .factor_i       (q_factor),
    .cls_i          (q_cls),
    .mode_i         (mode),
    .base_i         (base_q),
    .first_factor_i (first_factor_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .kind_o         (r_kind),
    .length_o       (r_length),
    .leading_o      (r_leading),
    .position_o     (r_position),
    .address_o      (r_address),
    .count_o        (r_count),
    .status_o       (r_status),
    .last_o         (m_axis_tlast)
  );

  // Output packing, first field lowest
  assign m_axis_tdata = OUT_W'({r_status, r_count, r_address, r_position, r_leading, r_length});
  assign m_axis_tuser = r_kind;

endmodule

`default_nettype wire

>>> design/stsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module stsd_checker #(
  parameter int unsigned MAX_DIMS     = 16,
  parameter int unsigned LENGTH_BITS  = 16,
  parameter int unsigned ADDRESS_BITS = 48,
  localparam int unsigned POS_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int unsigned CNT_W       = $clog2(MAX_DIMS + 1),
  localparam int unsigned OUT_BITS    = LENGTH_BITS + 2 * ADDRESS_BITS + POS_W + CNT_W + 3,
  localparam int unsigned OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [OUT_W-1:0]              m_tdata_i,
  input logic [stsd_pkg::KIND_W-1:0]   m_tuser_i,
  input logic                          m_tlast_i
);
  import stsd_pkg::*;

  localparam int unsigned O_ST = OUT_BITS - STATUS_W;

  logic [STATUS_W-1:0] st;

  assign st = m_tdata_i[O_ST+STATUS_W-1:O_ST];

  // A stalled result transfer holds still
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) &&
      $stable(m_tuser_i) && $stable(m_tlast_i))
    else $error("result changed while stalled");

  // Errors close the descriptor and carry a cause
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == KIND_ERROR) |-> m_tlast_i && (st != ST_OK))
    else $error("error result without tlast or cause");

  // Final address closes the descriptor with a clean status
  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == KIND_ADDR) |-> m_tlast_i && (st == ST_OK))
    else $error("address result malformed");

  // A kept dimension is never the closing result
  a_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == KIND_DIM) |-> !m_tlast_i && (st == ST_OK))
    else $error("dimension result malformed");

endmodule

bind strided_tensor_slice_descriptor_unit stsd_checker #(
  .MAX_DIMS     (MAX_DIMS),
  .LENGTH_BITS  (LENGTH_BITS),
  .ADDRESS_BITS (ADDRESS_BITS)
) u_stsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser),
  .m_tlast_i  (m_axis_tlast)
);

`default_nettype wire
